// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ----- src/dccpbt_pkg.sv -----
// ---------------------------------------------------------------------------
// dccpbt_pkg
// shared constants and types of the dcc packet bit transmitter
// ---------------------------------------------------------------------------
package dccpbt_pkg;

  // protocol constants
  localparam int MAX_PACKET_BYTES = 6;
  localparam int PREAMBLE_ONES    = 14;
  localparam int BITS_PER_BYTE    = 8;

  // field widths
  localparam int LEN_W     = 4;
  localparam int PKT_W     = 48;
  localparam int HP_W      = 16;
  localparam int BITCNT_W  = 4;
  localparam int BYTES_W   = $clog2(MAX_PACKET_BYTES + 1);
  localparam int IDX_W     = $clog2(MAX_PACKET_BYTES);
  localparam int PAD_W     = (8 * MAX_PACKET_BYTES > PKT_W) ? 8 * MAX_PACKET_BYTES : PKT_W;

  // stream widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HALF_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HALF_PERIOD = 1'd1;
  localparam logic [HP_W-1:0] ONE_HALF_RESET  = 16'd115;
  localparam logic [HP_W-1:0] ZERO_HALF_RESET = 16'd199;

  // queue between sequencer and output stage
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // one chosen bit with its packet flags
  typedef struct packed {
    logic bit_value;
    logic packet_taken;
    logic packet_rejected;
  } bit_info_t;

  // queue status seen by its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ----- src/dccpbt_front.sv -----
// ---------------------------------------------------------------------------
// dccpbt_front
// accepts timer events, runs the packet bit sequencer and queues chosen bits
// ---------------------------------------------------------------------------
module dccpbt_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_fire,
  input  logic                            line_high,
  input  logic [dccpbt_pkg::LEN_W-1:0]    packet_length,
  input  logic [dccpbt_pkg::PKT_W-1:0]    packet_bytes,
  output logic                            push,
  output dccpbt_pkg::bit_info_t           push_data
);
  import dccpbt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREAMBLE,
    ST_START,
    ST_DATA,
    ST_END
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [BITCNT_W-1:0]   bits_left_r, bits_left_nxt;
  logic [BYTES_W-1:0]    bytes_left_r, bytes_left_nxt;
  logic [IDX_W-1:0]      byte_idx_r, byte_idx_nxt;
  logic [7:0]            store_r [MAX_PACKET_BYTES];
  logic                  store_load;
  logic [PAD_W-1:0]      pkt_pad;
  logic [7:0]            cur_byte;
  logic [BITCNT_W-1:0]   bits_dec;
  logic [BYTES_W-1:0]    bytes_dec;
  logic                  event_go;

  assign event_go = in_fire && !line_high;
  assign pkt_pad  = PAD_W'(packet_bytes);
  assign cur_byte = store_r[byte_idx_r];
  assign bits_dec = (bits_left_r != '0) ? bits_left_r - 1'b1 : '0;
  assign bytes_dec = (bytes_left_r != '0) ? bytes_left_r - 1'b1 : '0;

  // next bit and sequencer state
  always_comb begin
    phase_nxt      = phase_r;
    bits_left_nxt  = bits_left_r;
    bytes_left_nxt = bytes_left_r;
    byte_idx_nxt   = byte_idx_r;
    store_load     = 1'b0;
    push           = 1'b0;
    push_data      = '{bit_value: 1'b1, packet_taken: 1'b0, packet_rejected: 1'b0};
    if (event_go) begin
      push = 1'b1;
      case (phase_r)
        ST_IDLE: begin
          if (packet_length == '0) begin
            push_data.bit_value = 1'b1;
          end else if (packet_length > LEN_W'(MAX_PACKET_BYTES)) begin
            push_data.packet_rejected = 1'b1;
          end else begin
            // take the packet and send the first preamble one now
            store_load             = 1'b1;
            push_data.packet_taken = 1'b1;
            bytes_left_nxt         = BYTES_W'(packet_length);
            byte_idx_nxt           = '0;
            bits_left_nxt          = BITCNT_W'(PREAMBLE_ONES - 1);
            phase_nxt              = (PREAMBLE_ONES > 1) ? ST_PREAMBLE : ST_START;
          end
        end
        ST_PREAMBLE: begin
          bits_left_nxt = bits_dec;
          if (bits_dec == '0) begin
            phase_nxt = ST_START;
          end
        end
        ST_START: begin
          push_data.bit_value = 1'b0;
          bits_left_nxt       = BITCNT_W'(BITS_PER_BYTE);
          phase_nxt           = ST_DATA;
        end
        ST_DATA: begin
          // msb first; an out-of-range count sends a zero
          if (bits_left_r != '0 && bits_left_r <= BITCNT_W'(BITS_PER_BYTE)) begin
            push_data.bit_value = cur_byte[bits_dec[2:0]];
          end else begin
            push_data.bit_value = 1'b0;
          end
          bits_left_nxt = bits_dec;
          if (bits_dec == '0) begin
            bytes_left_nxt = bytes_dec;
            byte_idx_nxt   = (byte_idx_r == IDX_W'(MAX_PACKET_BYTES - 1)) ?
                             byte_idx_r : byte_idx_r + 1'b1;
            phase_nxt      = (bytes_dec == '0) ? ST_END : ST_START;
          end
        end
        default: begin
          phase_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ST_IDLE;
      bits_left_r  <= BITCNT_W'(PREAMBLE_ONES);
      bytes_left_r <= '0;
      byte_idx_r   <= '0;
    end else begin
      phase_r      <= phase_nxt;
      bits_left_r  <= bits_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      byte_idx_r   <= byte_idx_nxt;
    end
  end

  // packet bytes, loaded when a packet is taken
  always_ff @(posedge clk) begin
    if (store_load) begin
      for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
        store_r[i] <= pkt_pad[8*i +: 8];
      end
    end
  end

endmodule

// ----- src/dccpbt_fifo.sv -----
// ---------------------------------------------------------------------------
// dccpbt_fifo
// short queue of chosen bits between sequencer and output stage
// ---------------------------------------------------------------------------
module dccpbt_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  dccpbt_pkg::bit_info_t     push_data,
  input  logic                      pop,
  output dccpbt_pkg::bit_info_t     pop_data,
  output dccpbt_pkg::fifo_status_t  status
);
  import dccpbt_pkg::*;

  bit_info_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic                    do_push, do_pop;

  assign status.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/dccpbt_back.sv -----
// ---------------------------------------------------------------------------
// dccpbt_back
// holds the half-period registers and drives the registered result beat
// ---------------------------------------------------------------------------
module dccpbt_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [dccpbt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dccpbt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  dccpbt_pkg::fifo_status_t            fifo_status,
  input  dccpbt_pkg::bit_info_t               fifo_data,
  output logic                                fifo_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dccpbt_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import dccpbt_pkg::*;

  logic [HP_W-1:0]   one_half_r, zero_half_r;
  logic              out_valid_r, out_valid_nxt;
  logic [HP_W-1:0]   half_period_r;
  bit_info_t         info_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_half_r  <= ONE_HALF_RESET;
      zero_half_r <= ZERO_HALF_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ONE_HALF_PERIOD:  one_half_r  <= cfg_data[HP_W-1:0];
        REG_ZERO_HALF_PERIOD: zero_half_r <= cfg_data[HP_W-1:0];
        default: ;
      endcase
    end
  end

  // refill the output register when it is empty or being taken
  assign fifo_pop      = !fifo_status.empty && (!out_valid_r || out_tready);
  assign out_valid_nxt = fifo_pop || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      info_r        <= fifo_data;
      half_period_r <= fifo_data.bit_value ? one_half_r : zero_half_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, info_r.packet_rejected, info_r.packet_taken,
                       info_r.bit_value, half_period_r};

endmodule

// ----- src/dcc_packet_bit_transmitter.sv -----
// ---------------------------------------------------------------------------
// dcc_packet_bit_transmitter
// dcc track signal bit sequencer driven by half-bit timer events
// ---------------------------------------------------------------------------
// Each input beat is one half-bit timer event. An event with the line high
// produces nothing; any other event produces one result beat naming the next
// dcc bit and the timer top for its half periods. In idle an offered packet
// of 1 to 6 bytes is taken and sent as 14 preamble ones, then per byte a start
// zero and 8 bits msb first, then a closing one. Throughput is one event per
// clock while the queue is not full. A two-entry queue feeds the registered
// output, so an event's result is held first in a queue entry and then in the
// output register. Half-period registers should be written only while no
// result is pending.
module dcc_packet_bit_transmitter (
  input  logic                                clk,
  input  logic                                rst_n,
  // event input; tdata: packet_length[3:0], packet_bytes[51:4], zero pad
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dccpbt_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: line_high
  input  logic                                in_tuser,
  // result output; tdata: half_period[15:0], bit_value[16],
  // packet_taken[17], packet_rejected[18], zero pad
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dccpbt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [dccpbt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dccpbt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dccpbt_pkg::*;

  logic          in_fire;
  logic          push, pop;
  bit_info_t     push_data, pop_data;
  fifo_status_t  fifo_status;

  assign in_tready = !fifo_status.full;
  assign in_fire   = in_tvalid && in_tready;

  // event sequencer
  dccpbt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .line_high     (in_tuser),
    .packet_length (in_tdata[LEN_W-1:0]),
    .packet_bytes  (in_tdata[LEN_W +: PKT_W]),
    .push          (push),
    .push_data     (push_data)
  );

  // bit queue
  dccpbt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (fifo_status)
  );

  // output stage
  dccpbt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fifo_status (fifo_status),
    .fifo_data   (pop_data),
    .fifo_pop    (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// ----- src/dccpbt_checker.sv -----
// ---------------------------------------------------------------------------
// dccpbt_checker
// port-level checks on the result stream of the transmitter
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dccpbt_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [dccpbt_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a rejected offer sends a one and never takes the packet
  `ASSERT_SAME(a_reject_one, clk, rst_n, out_tvalid && out_tdata[18], out_tdata[16] && !out_tdata[17])

  // a taken packet starts with a preamble one
  `ASSERT_SAME(a_taken_one, clk, rst_n, out_tvalid && out_tdata[17], out_tdata[16])

endmodule

bind dcc_packet_bit_transmitter dccpbt_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
